// File: rtl/ccrb_pkg.sv
package ccrb_pkg;

    localparam logic [2:0] FUNC_NORMAL  = 3'd0;
    localparam logic [2:0] FUNC_POINT_A = 3'd1;
    localparam logic [2:0] FUNC_POINT_B = 3'd2;
    localparam logic [2:0] FUNC_CENTRE_A = 3'd3;
    localparam logic [2:0] FUNC_COMPUTE = 3'd4;

    localparam logic REG_ROW_COUNT   = 1'b0;
    localparam logic REG_ERROR_SCALE = 1'b1;

    // sqrt(1/2) in Q2.30.
    localparam longint HALF_ROOT_Q30 = 64'sd759250125;

    localparam logic signed [31:0] MAX_Q = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN_Q = 32'sh8000_0000;

    typedef logic signed [67:0] t_wide;
    typedef logic signed [32:0] t_opnd;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [31:0] scalar;
        logic               swap;
        logic               body_present;
    } t_item;

    typedef struct packed {
        logic [1:0]         row_index;
        logic               side;
        logic signed [31:0] lin_x;
        logic signed [31:0] lin_y;
        logic signed [31:0] lin_z;
        logic signed [31:0] ang_x;
        logic signed [31:0] ang_y;
        logic signed [31:0] ang_z;
        logic signed [31:0] lower_limit;
        logic signed [31:0] upper_limit;
        logic signed [31:0] row_error;
        logic               last;
    } t_result;

    function automatic logic signed [31:0] f_sat(input t_wide v);
        logic signed [31:0] r;
        if (v > t_wide'(MAX_Q)) begin
            r = MAX_Q;
        end else if (v < t_wide'(MIN_Q)) begin
            r = MIN_Q;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic t_opnd f_ext(input logic signed [31:0] v);
        return {v[31], v};
    endfunction

    function automatic logic signed [31:0] f_neg(input logic signed [31:0] v);
        return f_sat(-t_wide'(f_ext(v)));
    endfunction

endpackage

// File: rtl/ccrb_lane.sv
module ccrb_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  ccrb_pkg::t_opnd     i_a,
    input  ccrb_pkg::t_opnd     i_b,
    output ccrb_pkg::t_wide     o_p
);

    logic signed [65:0] w_prod;
    logic signed [65:0] w_shr;
    ccrb_pkg::t_wide    r_p;

    // Arithmetic shift gives the floor of the scaled product.
    assign w_prod = i_a * i_b;
    assign w_shr  = w_prod >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        r_p <= {{2{w_shr[65]}}, w_shr};
    end

    assign o_p = r_p;

endmodule

// File: rtl/contact_constraint_row_builder.sv
// Contact constraint row builder, Q16.16 fixed point.
// Input channel: an item is transferred at a rising edge with i_start high and
// o_busy low. Items with func 0 to 3 only store a vector (and a scalar or flag)
// and leave o_busy low; func 5 to 7 are dropped. A func 4 item starts the
// computation and raises o_busy until the last row half has been produced.
// Result channel: each row half is shown on o_result for one cycle with
// o_strobe high; the receiver cannot stall it. Halves come in order normal A,
// normal B, tangent 1 A/B, tangent 2 A/B, and last marks the final one.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 row count, 1 error scale) at once; write only while idle.
// A compute item steps through the setup states PRE, SQ and AK, then R1, R2,
// R3 and RY for each Newton step of the reciprocal square root
// (RSQRT_ITERATIONS steps), then the tangent states TA, TB and TC, then CA,
// CB and CO for each row half. The three multiplier lanes (one per vector
// component) are shared by the steps that multiply, and the chain of dependent
// products in the reciprocal square root runs on the first lane alone.
// Reset clears the vectors stored by func 0 to 3, sets row count 3 and error scale 1.0.
module contact_constraint_row_builder #(
    parameter int FRAC_BITS        = 16,
    parameter int RSQRT_ITERATIONS = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  ccrb_pkg::t_item     i_item,
    output logic                o_busy,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [30:0]         i_cfg_data,
    output logic                o_strobe,
    output ccrb_pkg::t_result   o_result
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PRE  = 4'd1;
    localparam logic [3:0] S_SQ   = 4'd2;
    localparam logic [3:0] S_AK   = 4'd3;
    localparam logic [3:0] S_R1   = 4'd4;
    localparam logic [3:0] S_R2   = 4'd5;
    localparam logic [3:0] S_R3   = 4'd6;
    localparam logic [3:0] S_RY   = 4'd7;
    localparam logic [3:0] S_TA   = 4'd8;
    localparam logic [3:0] S_TB   = 4'd9;
    localparam logic [3:0] S_TC   = 4'd10;
    localparam logic [3:0] S_CA   = 4'd11;
    localparam logic [3:0] S_CB   = 4'd12;
    localparam logic [3:0] S_CO   = 4'd13;

    localparam int IT_W = $clog2(RSQRT_ITERATIONS + 1);
    localparam longint LIM_L = (ccrb_pkg::HALF_ROOT_Q30 + (64'sd1 <<< (29 - FRAC_BITS)))
                               >>> (30 - FRAC_BITS);
    localparam logic [32:0] LIM = 33'(LIM_L);
    localparam ccrb_pkg::t_opnd THREE_ONE = 33'(64'd3 << FRAC_BITS);

    logic [3:0]         r_state, n_state;
    logic [IT_W-1:0]    r_it;
    logic [1:0]         r_row;
    logic               r_side;

    // Loaded operands.
    logic signed [31:0] r_nv [3];
    logic signed [31:0] r_pa [3];
    logic signed [31:0] r_pb [3];
    logic signed [31:0] r_ca [3];
    logic signed [31:0] r_cb [3];
    logic signed [31:0] r_dist, r_fa, r_fb;
    logic               r_swap, r_pres;
    logic [1:0]         r_row_count;
    logic [30:0]        r_error_scale;

    // Working values.
    logic signed [31:0] r_dir [3][3];
    logic signed [31:0] r_ra [3];
    logic signed [31:0] r_rb [3];
    logic signed [31:0] r_a, r_y, r_fric, r_err;
    logic               r_zhi;
    ccrb_pkg::t_wide    r_cp [3];

    logic               r_strobe;
    ccrb_pkg::t_result  r_res;

    ccrb_pkg::t_opnd    w_opa [3];
    ccrb_pkg::t_opnd    w_opb [3];
    ccrb_pkg::t_wide    w_p [3];

    logic               w_take;
    logic [1:0]         w_rows;
    logic               w_last;
    logic [32:0]        w_az;
    logic signed [31:0] w_s [3];
    logic signed [31:0] w_asum;
    logic signed [31:0] w_y0;
    logic signed [31:0] w_ynext;

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_lane
            ccrb_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
                .i_clk (i_clk),
                .i_a   (w_opa[g]),
                .i_b   (w_opb[g]),
                .o_p   (w_p[g])
            );
        end
    endgenerate

    assign w_take = i_start && (r_state == S_IDLE);
    assign w_rows = (r_row_count == 2'd0) ? 2'd1 : r_row_count;
    assign w_last = r_side && (r_row == w_rows - 2'd1);
    assign w_az   = r_dir[0][2][31] ? 33'(-ccrb_pkg::f_ext(r_dir[0][2]))
                                    : 33'(ccrb_pkg::f_ext(r_dir[0][2]));
    assign w_asum = ccrb_pkg::f_sat(w_p[0] + w_p[1]);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_s[i] = ccrb_pkg::f_sat(w_p[i]);
        end
    end

    // Start value of the reciprocal square root from the leading one of a.
    always_comb begin
        int     msb, v, c, sh;
        longint tmp;
        msb = 0;
        for (int i = 0; i < 31; i++) begin
            if (w_asum[i]) begin
                msb = i;
            end
        end
        v  = msb - FRAC_BITS + 2;
        c  = v >>> 1;
        sh = FRAC_BITS - c;
        if (sh >= 0) begin
            tmp = longint'((64'd3 << sh) >> 1);
        end else begin
            tmp = longint'(64'd3 >> (1 - sh));
        end
        if (w_asum <= 32'sd0) begin
            w_y0 = 32'sd0;
        end else if (tmp > 64'sh7FFF_FFFF) begin
            w_y0 = ccrb_pkg::MAX_Q;
        end else begin
            w_y0 = tmp[31:0];
        end
    end

    always_comb begin
        ccrb_pkg::t_wide h;
        h = w_p[0] >>> 1;
        if (w_p[0] < 0) begin
            w_ynext = 32'sd0;
        end else begin
            w_ynext = ccrb_pkg::f_sat(h);
        end
    end

    // Operand selection for the three lanes.
    always_comb begin
        logic signed [31:0] b [3];
        logic signed [31:0] d [3];
        for (int i = 0; i < 3; i++) begin
            w_opa[i] = '0;
            w_opb[i] = '0;
            b[i] = r_side ? r_rb[i] : r_ra[i];
            d[i] = r_dir[r_row][i];
        end
        case (r_state)
            S_SQ: begin
                if (w_az > LIM) begin
                    w_opa[0] = ccrb_pkg::f_ext(r_dir[0][1]);
                    w_opb[0] = ccrb_pkg::f_ext(r_dir[0][1]);
                    w_opa[1] = ccrb_pkg::f_ext(r_dir[0][2]);
                    w_opb[1] = ccrb_pkg::f_ext(r_dir[0][2]);
                end else begin
                    w_opa[0] = ccrb_pkg::f_ext(r_dir[0][0]);
                    w_opb[0] = ccrb_pkg::f_ext(r_dir[0][0]);
                    w_opa[1] = ccrb_pkg::f_ext(r_dir[0][1]);
                    w_opb[1] = ccrb_pkg::f_ext(r_dir[0][1]);
                end
                w_opa[2] = ccrb_pkg::f_ext(r_fa);
                w_opb[2] = ccrb_pkg::f_ext(r_fb);
            end
            S_R1: begin
                w_opa[0] = ccrb_pkg::f_ext(r_a);
                w_opb[0] = ccrb_pkg::f_ext(r_y);
            end
            S_R2: begin
                w_opa[0] = ccrb_pkg::f_ext(w_s[0]);
                w_opb[0] = ccrb_pkg::f_ext(r_y);
            end
            S_R3: begin
                w_opa[0] = ccrb_pkg::f_ext(r_y);
                w_opb[0] = THREE_ONE - ccrb_pkg::f_ext(w_s[0]);
            end
            S_TA: begin
                if (r_zhi) begin
                    w_opa[0] = -ccrb_pkg::f_ext(r_dir[0][2]);
                    w_opa[1] = ccrb_pkg::f_ext(r_dir[0][1]);
                end else begin
                    w_opa[0] = -ccrb_pkg::f_ext(r_dir[0][1]);
                    w_opa[1] = ccrb_pkg::f_ext(r_dir[0][0]);
                end
                w_opb[0] = ccrb_pkg::f_ext(r_y);
                w_opb[1] = ccrb_pkg::f_ext(r_y);
                w_opa[2] = ccrb_pkg::f_ext(r_a);
                w_opb[2] = ccrb_pkg::f_ext(r_y);
            end
            S_TB: begin
                // The first tangent leaves the lanes this cycle and feeds the second.
                if (r_zhi) begin
                    w_opa[0] = -ccrb_pkg::f_ext(r_dir[0][0]);
                    w_opb[0] = ccrb_pkg::f_ext(w_s[1]);
                    w_opa[1] = ccrb_pkg::f_ext(r_dir[0][0]);
                    w_opb[1] = ccrb_pkg::f_ext(w_s[0]);
                end else begin
                    w_opa[0] = -ccrb_pkg::f_ext(r_dir[0][2]);
                    w_opb[0] = ccrb_pkg::f_ext(w_s[1]);
                    w_opa[1] = ccrb_pkg::f_ext(r_dir[0][2]);
                    w_opb[1] = ccrb_pkg::f_ext(w_s[0]);
                end
                w_opa[2] = -ccrb_pkg::f_ext(r_dist);
                w_opb[2] = {2'b00, r_error_scale};
            end
            S_CA: begin
                for (int i = 0; i < 3; i++) begin
                    w_opa[i] = ccrb_pkg::f_ext(b[(i + 1) % 3]);
                    w_opb[i] = ccrb_pkg::f_ext(d[(i + 2) % 3]);
                end
            end
            S_CB: begin
                for (int i = 0; i < 3; i++) begin
                    w_opa[i] = ccrb_pkg::f_ext(b[(i + 2) % 3]);
                    w_opb[i] = ccrb_pkg::f_ext(d[(i + 1) % 3]);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_take && (i_item.func == ccrb_pkg::FUNC_COMPUTE)) begin
                    n_state = S_PRE;
                end
            end
            S_PRE: n_state = S_SQ;
            S_SQ:  n_state = S_AK;
            S_AK:  n_state = S_R1;
            S_R1:  n_state = S_R2;
            S_R2:  n_state = S_R3;
            S_R3:  n_state = S_RY;
            S_RY:  n_state = (r_it == IT_W'(RSQRT_ITERATIONS - 1)) ? S_TA : S_R1;
            S_TA:  n_state = S_TB;
            S_TB:  n_state = S_TC;
            S_TC:  n_state = S_CA;
            S_CA:  n_state = S_CB;
            S_CB:  n_state = S_CO;
            S_CO:  n_state = w_last ? S_IDLE : S_CA;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_strobe      <= 1'b0;
            r_row_count   <= 2'd3;
            r_error_scale <= 31'd65536;
            r_dist        <= '0;
            r_fa          <= '0;
            r_swap        <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_nv[i] <= '0;
                r_pa[i] <= '0;
                r_pb[i] <= '0;
                r_ca[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_CO);
            if (i_cfg_we) begin
                if (i_cfg_idx == ccrb_pkg::REG_ROW_COUNT) begin
                    r_row_count <= i_cfg_data[1:0];
                end else begin
                    r_error_scale <= i_cfg_data;
                end
            end
            if (w_take) begin
                case (i_item.func)
                    ccrb_pkg::FUNC_NORMAL: begin
                        r_nv[0] <= i_item.vec_x;
                        r_nv[1] <= i_item.vec_y;
                        r_nv[2] <= i_item.vec_z;
                        r_dist  <= i_item.scalar;
                        r_swap  <= i_item.swap;
                    end
                    ccrb_pkg::FUNC_POINT_A: begin
                        r_pa[0] <= i_item.vec_x;
                        r_pa[1] <= i_item.vec_y;
                        r_pa[2] <= i_item.vec_z;
                    end
                    ccrb_pkg::FUNC_POINT_B: begin
                        r_pb[0] <= i_item.vec_x;
                        r_pb[1] <= i_item.vec_y;
                        r_pb[2] <= i_item.vec_z;
                    end
                    ccrb_pkg::FUNC_CENTRE_A: begin
                        r_ca[0] <= i_item.vec_x;
                        r_ca[1] <= i_item.vec_y;
                        r_ca[2] <= i_item.vec_z;
                        r_fa    <= i_item.scalar;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_take && (i_item.func == ccrb_pkg::FUNC_COMPUTE)) begin
            r_cb[0] <= i_item.vec_x;
            r_cb[1] <= i_item.vec_y;
            r_cb[2] <= i_item.vec_z;
            r_fb    <= i_item.scalar;
            r_pres  <= i_item.body_present;
        end
        case (r_state)
            S_PRE: begin
                for (int i = 0; i < 3; i++) begin
                    r_dir[0][i] <= r_swap ? ccrb_pkg::f_neg(r_nv[i]) : r_nv[i];
                    r_ra[i] <= ccrb_pkg::f_sat(ccrb_pkg::t_wide'(ccrb_pkg::f_ext(r_pa[i]))
                                             - ccrb_pkg::t_wide'(ccrb_pkg::f_ext(r_ca[i])));
                    r_rb[i] <= r_pres
                        ? ccrb_pkg::f_sat(ccrb_pkg::t_wide'(ccrb_pkg::f_ext(r_pb[i]))
                                        - ccrb_pkg::t_wide'(ccrb_pkg::f_ext(r_cb[i])))
                        : 32'sd0;
                end
            end
            S_SQ: r_zhi <= (w_az > LIM);
            S_AK: begin
                r_a    <= w_asum;
                r_y    <= w_y0;
                r_fric <= r_pres ? w_s[2] : r_fa;
                r_it   <= '0;
            end
            S_RY: begin
                r_y  <= w_ynext;
                r_it <= r_it + IT_W'(1);
            end
            S_TB: begin
                if (r_zhi) begin
                    r_dir[1][0] <= 32'sd0;
                    r_dir[1][1] <= w_s[0];
                    r_dir[1][2] <= w_s[1];
                    r_dir[2][0] <= w_s[2];
                end else begin
                    r_dir[1][0] <= w_s[0];
                    r_dir[1][1] <= w_s[1];
                    r_dir[1][2] <= 32'sd0;
                    r_dir[2][2] <= w_s[2];
                end
            end
            S_TC: begin
                if (r_zhi) begin
                    r_dir[2][1] <= w_s[0];
                    r_dir[2][2] <= w_s[1];
                end else begin
                    r_dir[2][0] <= w_s[0];
                    r_dir[2][1] <= w_s[1];
                end
                r_err  <= w_s[2];
                r_row  <= 2'd0;
                r_side <= 1'b0;
            end
            S_CB: begin
                for (int i = 0; i < 3; i++) begin
                    r_cp[i] <= w_p[i];
                end
            end
            S_CO: begin
                if (r_side) begin
                    r_row <= r_row + 2'd1;
                end
                r_side <= !r_side;
            end
            default: begin
            end
        endcase
    end

    // Merge of the lane results into one row half.
    always_ff @(posedge i_clk) begin
        logic signed [31:0] ang [3];
        logic signed [31:0] lin [3];
        for (int i = 0; i < 3; i++) begin
            ang[i] = ccrb_pkg::f_sat(r_cp[i] - w_p[i]);
            lin[i] = r_dir[r_row][i];
            if (r_side) begin
                if (r_pres) begin
                    ang[i] = ccrb_pkg::f_neg(ang[i]);
                    lin[i] = ccrb_pkg::f_neg(lin[i]);
                end else begin
                    ang[i] = 32'sd0;
                    lin[i] = 32'sd0;
                end
            end
        end
        if (r_state == S_CO) begin
            r_res.row_index <= r_row;
            r_res.side      <= r_side;
            r_res.lin_x     <= lin[0];
            r_res.lin_y     <= lin[1];
            r_res.lin_z     <= lin[2];
            r_res.ang_x     <= ang[0];
            r_res.ang_y     <= ang[1];
            r_res.ang_z     <= ang[2];
            if (r_row == 2'd0) begin
                r_res.lower_limit <= 32'sd0;
                r_res.upper_limit <= ccrb_pkg::MAX_Q;
                r_res.row_error   <= r_err;
            end else begin
                r_res.lower_limit <= ccrb_pkg::f_neg(r_fric);
                r_res.upper_limit <= r_fric;
                r_res.row_error   <= 32'sd0;
            end
            r_res.last <= w_last;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

endmodule

// File: rtl/ccrb_checker.sv
module ccrb_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_busy,
    input logic                o_strobe,
    input ccrb_pkg::t_result   o_result
);

    // Result strobes never come back to back.
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("back to back result strobes");

    a_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |-> o_busy)
        else $error("block went idle before the last row half");

    a_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.side) |-> !o_result.last)
        else $error("last marked on a body A half");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_strobe && !o_busy))
        else $error("activity right after reset");

endmodule

bind contact_constraint_row_builder ccrb_checker u_ccrb_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_busy   (o_busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

// File: test/contact_row_checker.sv
`timescale 1ns / 1ps

module contact_row_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  ccrb_pkg::t_item     i_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [30:0]         i_cfg_data,
    input  logic                i_strobe,
    input  ccrb_pkg::t_result   i_result,
    output int                  o_fail_count,
    output int                  o_pending
);

    // Shadow of the stored contact data and of the registers.
    logic signed [31:0] normal_q [3];
    logic signed [31:0] point_a_q [3];
    logic signed [31:0] point_b_q [3];
    logic signed [31:0] centre_a_q [3];
    logic signed [31:0] distance_q;
    logic signed [31:0] friction_a_q;
    logic               swap_q;
    logic [1:0]         rows_q;
    logic [30:0]        err_scale_q;

    ccrb_pkg::t_result row_queue [$];

    assign o_pending = row_queue.size();

    function automatic logic signed [31:0] sat64(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Floor-rounded fixed point product; >>> on a signed value floors.
    function automatic longint qmul(input longint a, input longint b);
        longint p;
        p = a * b;
        return p >>> 16;
    endfunction

    function automatic logic signed [31:0] negq(input logic signed [31:0] v);
        return sat64(-longint'(v));
    endfunction

    function automatic logic signed [31:0] inv_sqrt(input logic signed [31:0] a);
        int     msb;
        int     e;
        int     c;
        int     sh;
        longint y;
        longint t;
        longint n;
        if (a <= 0) return 0;
        msb = 0;
        for (int i = 30; i >= 0; i--) begin
            if (a[i] && msb == 0) msb = i;
        end
        e = msb - 16;
        c = (e + 2 >= 0) ? (e + 2) / 2 : -((-(e + 2) + 1) / 2);
        sh = 16 - c;
        if (sh >= 0) y = (longint'(3) << sh) >> 1;
        else y = 3 >> (1 - sh);
        if (y > 64'sd2147483647) y = 64'sd2147483647;
        for (int i = 0; i < 4; i++) begin
            t = sat64(qmul(sat64(qmul(a, y)), y));
            n = qmul(y, 3 * 65536 - t);
            n = (n >= 0) ? (n >>> 1) : 0;
            y = (n > 64'sd2147483647) ? 64'sd2147483647 : n;
        end
        return y[31:0];
    endfunction

    function automatic void cross_q(output logic signed [31:0] o [3],
                                    input logic signed [31:0] b [3],
                                    input logic signed [31:0] c [3]);
        o[0] = sat64(qmul(b[1], c[2]) - qmul(b[2], c[1]));
        o[1] = sat64(qmul(b[2], c[0]) - qmul(b[0], c[2]));
        o[2] = sat64(qmul(b[0], c[1]) - qmul(b[1], c[0]));
    endfunction

    // Works out every row half of one compute transfer.
    task automatic predict_rows(input ccrb_pkg::t_item it);
        logic signed [31:0] n [3];
        logic signed [31:0] ra [3];
        logic signed [31:0] rb [3];
        logic signed [31:0] dirs [3][3];
        logic signed [31:0] ang [3];
        logic signed [31:0] a;
        logic signed [31:0] k;
        logic signed [31:0] fric;
        logic signed [31:0] centre_b [3];
        longint             az;
        longint             lim;
        int                 rows;
        ccrb_pkg::t_result  r;
        centre_b[0] = it.vec_x;
        centre_b[1] = it.vec_y;
        centre_b[2] = it.vec_z;
        for (int i = 0; i < 3; i++) begin
            n[i] = swap_q ? negq(normal_q[i]) : normal_q[i];
            ra[i] = sat64(longint'(point_a_q[i]) - centre_a_q[i]);
            rb[i] = it.body_present ? sat64(longint'(point_b_q[i]) - centre_b[i]) : 0;
            dirs[0][i] = n[i];
        end
        lim = (ccrb_pkg::HALF_ROOT_Q30 + (64'sd1 << 13)) >>> 14;
        az = (n[2] < 0) ? -longint'(n[2]) : longint'(n[2]);
        if (az > lim) begin
            a = sat64(qmul(n[1], n[1]) + qmul(n[2], n[2]));
            k = inv_sqrt(a);
            dirs[1][0] = 0;
            dirs[1][1] = sat64(qmul(-longint'(n[2]), k));
            dirs[1][2] = sat64(qmul(n[1], k));
            dirs[2][0] = sat64(qmul(a, k));
            dirs[2][1] = sat64(qmul(-longint'(n[0]), dirs[1][2]));
            dirs[2][2] = sat64(qmul(n[0], dirs[1][1]));
        end else begin
            a = sat64(qmul(n[0], n[0]) + qmul(n[1], n[1]));
            k = inv_sqrt(a);
            dirs[1][0] = sat64(qmul(-longint'(n[1]), k));
            dirs[1][1] = sat64(qmul(n[0], k));
            dirs[1][2] = 0;
            dirs[2][0] = sat64(qmul(-longint'(n[2]), dirs[1][1]));
            dirs[2][1] = sat64(qmul(n[2], dirs[1][0]));
            dirs[2][2] = sat64(qmul(a, k));
        end
        fric = it.body_present ? sat64(qmul(friction_a_q, it.scalar)) : friction_a_q;
        rows = (rows_q == 0) ? 1 : rows_q;
        for (int ri = 0; ri < rows; ri++) begin
            r = '0;
            r.row_index = ri[1:0];
            if (ri == 0) begin
                r.lower_limit = 0;
                r.upper_limit = ccrb_pkg::MAX_Q;
                r.row_error = sat64(qmul(-longint'(distance_q), longint'(err_scale_q)));
            end else begin
                r.lower_limit = negq(fric);
                r.upper_limit = fric;
                r.row_error = 0;
            end
            cross_q(ang, ra, dirs[ri]);
            r.side = 1'b0;
            {r.lin_x, r.lin_y, r.lin_z} = {dirs[ri][0], dirs[ri][1], dirs[ri][2]};
            {r.ang_x, r.ang_y, r.ang_z} = {ang[0], ang[1], ang[2]};
            row_queue.push_back(r);
            r.side = 1'b1;
            if (it.body_present) begin
                cross_q(ang, rb, dirs[ri]);
                r.lin_x = negq(dirs[ri][0]);
                r.lin_y = negq(dirs[ri][1]);
                r.lin_z = negq(dirs[ri][2]);
                r.ang_x = negq(ang[0]);
                r.ang_y = negq(ang[1]);
                r.ang_z = negq(ang[2]);
            end else begin
                {r.lin_x, r.lin_y, r.lin_z, r.ang_x, r.ang_y, r.ang_z} = '0;
            end
            r.last = (ri == rows - 1);
            row_queue.push_back(r);
        end
    endtask

    task automatic compare_field(input string name, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
        if (want !== got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        ccrb_pkg::t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                normal_q[i] = 0;
                point_a_q[i] = 0;
                point_b_q[i] = 0;
                centre_a_q[i] = 0;
            end
            distance_q = 0;
            friction_a_q = 0;
            swap_q = 0;
            rows_q = 2'd3;
            err_scale_q = 31'd65536;
            row_queue.delete();
            o_fail_count = 0;
        end else begin
            if (i_strobe) begin
                if (row_queue.size() == 0) begin
                    $error("row half with no expectation waiting");
                    o_fail_count++;
                end else begin
                    want = row_queue.pop_front();
                    compare_field("row_index", want.row_index, i_result.row_index);
                    compare_field("side", want.side, i_result.side);
                    compare_field("lin_x", want.lin_x, i_result.lin_x);
                    compare_field("lin_y", want.lin_y, i_result.lin_y);
                    compare_field("lin_z", want.lin_z, i_result.lin_z);
                    compare_field("ang_x", want.ang_x, i_result.ang_x);
                    compare_field("ang_y", want.ang_y, i_result.ang_y);
                    compare_field("ang_z", want.ang_z, i_result.ang_z);
                    compare_field("lower_limit", want.lower_limit, i_result.lower_limit);
                    compare_field("upper_limit", want.upper_limit, i_result.upper_limit);
                    compare_field("row_error", want.row_error, i_result.row_error);
                    compare_field("last", want.last, i_result.last);
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == ccrb_pkg::REG_ROW_COUNT) rows_q = i_cfg_data[1:0];
                else err_scale_q = i_cfg_data;
            end
            if (i_start && !i_busy) begin
                case (i_item.func)
                    ccrb_pkg::FUNC_NORMAL: begin
                        {normal_q[0], normal_q[1], normal_q[2]} =
                            {i_item.vec_x, i_item.vec_y, i_item.vec_z};
                        distance_q = i_item.scalar;
                        swap_q = i_item.swap;
                    end
                    ccrb_pkg::FUNC_POINT_A: begin
                        {point_a_q[0], point_a_q[1], point_a_q[2]} =
                            {i_item.vec_x, i_item.vec_y, i_item.vec_z};
                    end
                    ccrb_pkg::FUNC_POINT_B: begin
                        {point_b_q[0], point_b_q[1], point_b_q[2]} =
                            {i_item.vec_x, i_item.vec_y, i_item.vec_z};
                    end
                    ccrb_pkg::FUNC_CENTRE_A: begin
                        {centre_a_q[0], centre_a_q[1], centre_a_q[2]} =
                            {i_item.vec_x, i_item.vec_y, i_item.vec_z};
                        friction_a_q = i_item.scalar;
                    end
                    ccrb_pkg::FUNC_COMPUTE: predict_rows(i_item);
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: test/contact_constraint_row_builder_test.sv
`timescale 1ns / 1ps

module contact_constraint_row_builder_test;

    // Bound on one compute transfer, used as the settle time in drain().
    localparam int COMPUTE_CYCLES = 40;
    localparam int CYCLE_LIMIT    = 400000;

    logic               clk;
    logic               rst_n;
    logic               start;
    ccrb_pkg::t_item    item;
    logic               busy;
    logic               cfg_we;
    logic               cfg_idx;
    logic [30:0]        cfg_data;
    logic               strobe;
    ccrb_pkg::t_result  result;
    int                 fail_count;
    int                 pending;
    int                 cycle_count;

    contact_constraint_row_builder u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_start    (start),
        .i_item     (item),
        .o_busy     (busy),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_strobe   (strobe),
        .o_result   (result)
    );

    contact_row_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (item),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_strobe     (strobe),
        .i_result     (result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The watchdog ends a run that hangs.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // The sender works in bursts: gap_left counts idle cycles still owed.
    int burst_left;
    int gap_left;

    // Offers one item and holds it until the block takes the transfer.
    // Start is lowered only at the beginning of a gap, so it gets a single
    // assignment in any one step; the caller or drain() lowers it afterwards.
    task automatic send_item(input ccrb_pkg::t_item it);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (gap_left > 0) begin
            start <= 1'b0;
            repeat (gap_left) @(posedge clk);
            gap_left = 0;
        end
        burst_left--;
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy) @(posedge clk);
        // Sometimes break the burst with a short gap.
        if (burst_left > 0 && $urandom_range(0, 2) == 0) gap_left = $urandom_range(1, 4);
    endtask

    // Picks a value that favors the extremes and the useful unit range.
    function automatic logic signed [31:0] pick_q();
        case ($urandom_range(0, 9))
            0: return ccrb_pkg::MAX_Q;
            1: return ccrb_pkg::MIN_Q;
            2: return 0;
            3, 4: return $urandom;
            5: return $signed($urandom_range(0, 65536)) * (($urandom_range(0, 1) != 0) ? 1 : -1);
            default: return $signed($urandom_range(0, 8 * 65536)) - 4 * 65536;
        endcase
    endfunction

    function automatic ccrb_pkg::t_item make_item(input logic [2:0] f);
        ccrb_pkg::t_item it;
        it.func = f;
        it.vec_x = pick_q();
        it.vec_y = pick_q();
        it.vec_z = pick_q();
        it.scalar = pick_q();
        it.swap = $urandom_range(0, 1);
        it.body_present = $urandom_range(0, 1);
        return it;
    endfunction

    // A well-formed contact: four loads then the compute.
    task automatic send_contact();
        for (int f = 0; f <= 4; f++) send_item(make_item(f[2:0]));
    endtask

    // Waits until every row half has arrived, then lets the block settle.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy) @(posedge clk);
        repeat (COMPUTE_CYCLES) @(posedge clk);
    endtask

    // One write, then cfg_we is lowered before the task returns, so back-to-back writes never clash.
    task automatic write_reg(input logic idx, input logic [30:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    ccrb_pkg::t_item it;
    int              sent;

    initial begin
        cycle_count = 0;
        burst_left = 0;
        gap_left = 0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_idx = ccrb_pkg::REG_ROW_COUNT;
        cfg_data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: compute straight after reset uses all-zero state.
        it = '0;
        it.func = ccrb_pkg::FUNC_COMPUTE;
        send_item(it);
        // A normal mostly along z takes the other plane-space branch.
        it = '0;
        it.func = ccrb_pkg::FUNC_NORMAL;
        it.vec_z = 32'sd65536;
        it.scalar = -32'sd4096;
        send_item(it);
        it.func = ccrb_pkg::FUNC_COMPUTE;
        it.body_present = 1'b1;
        it.scalar = 32'sd32768;
        send_item(it);
        // Extreme fields with swap set and every bit of the vectors.
        it.func = ccrb_pkg::FUNC_NORMAL;
        {it.vec_x, it.vec_y, it.vec_z, it.scalar} =
            {ccrb_pkg::MIN_Q, ccrb_pkg::MAX_Q, ccrb_pkg::MIN_Q, ccrb_pkg::MIN_Q};
        it.swap = 1'b1;
        send_item(it);
        it.func = ccrb_pkg::FUNC_POINT_A;
        {it.vec_x, it.vec_y, it.vec_z} = {ccrb_pkg::MAX_Q, ccrb_pkg::MIN_Q, ccrb_pkg::MAX_Q};
        send_item(it);
        it.func = ccrb_pkg::FUNC_POINT_B;
        send_item(it);
        it.func = ccrb_pkg::FUNC_CENTRE_A;
        {it.vec_x, it.vec_y, it.vec_z, it.scalar} =
            {ccrb_pkg::MIN_Q, ccrb_pkg::MAX_Q, ccrb_pkg::MIN_Q, ccrb_pkg::MAX_Q};
        send_item(it);
        // Unused codes are dropped.
        for (int f = 5; f <= 7; f++) begin
            it.func = f[2:0];
            send_item(it);
        end
        it.func = ccrb_pkg::FUNC_COMPUTE;
        it.body_present = 1'b1;
        send_item(it);
        it.body_present = 1'b0;
        send_item(it);
        drain();

        // Register phases: row count 0 acts as 1, then the scale extremes.
        write_reg(ccrb_pkg::REG_ROW_COUNT, 31'd0);
        write_reg(ccrb_pkg::REG_ERROR_SCALE, 31'h7FFF_FFFF);
        send_contact();
        drain();
        write_reg(ccrb_pkg::REG_ROW_COUNT, 31'd1);
        write_reg(ccrb_pkg::REG_ERROR_SCALE, 31'd0);
        send_contact();
        drain();

        sent = 0;
        for (int phase = 0; phase < 4; phase++) begin
            write_reg(ccrb_pkg::REG_ROW_COUNT,
                      (phase == 3) ? 31'd3 : 31'($urandom_range(1, 3)));
            write_reg(ccrb_pkg::REG_ERROR_SCALE,
                      (phase == 2) ? 31'h7FFF_FFFF : 31'($urandom));
            for (int n = 0; n < 18; n++) begin
                if ($urandom_range(0, 4) != 0) begin
                    send_contact();
                    sent += 5;
                end else begin
                    send_item(make_item(3'($urandom_range(0, 7))));
                    sent++;
                end
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
